// ===== rtl/bffa_pkg.sv =====
// ============================================================================
// bffa_pkg: shared definitions for the bitmap first-free allocator
// Field widths, stream packing, status and register codes, and the result
// record of the lowest-free-bit search unit.
// ============================================================================
package bffa_pkg;

    // Payload field widths
    localparam int NUM_W      = 14;
    localparam int CNT_W      = 14;
    localparam int STATUS_W   = 2;

    // Map words are read one row of this many bits at a time
    localparam int WORD_W     = 64;
    localparam int BIT_W      = 6;

    // Default map size and reset value of the size registers
    localparam int MAP_BITS_DEF = 8192;
    localparam int SIZE_RESET   = 8192;

    // Stream and configuration port widths
    localparam int S_TDATA_W  = 16;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 2;
    localparam int M_PAD_W    = M_TDATA_W - 2 * NUM_W;
    localparam int CFG_IDX_W  = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    // Request kinds and pools
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;
    localparam logic POOL_INODE = 1'b0;
    localparam logic POOL_BLOCK = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

    // Outcome of searching one map word for its lowest free bit
    typedef struct packed {
        logic              found;
        logic [BIT_W-1:0]  bit_idx;
        logic [WORD_W-1:0] set_word;
    } scan_res_t;

endpackage

// ===== rtl/bffa_map_ram.sv =====
// ============================================================================
// bffa_map_ram: allocation map storage
// One write port and one read port with registered read data. Both pools
// share the array; the pool selects the upper address bit.
// ============================================================================
module bffa_map_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 64
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port, read every cycle
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/bffa_scan_unit.sv =====
// ============================================================================
// bffa_scan_unit: lowest free bit search over one map word
// Masks off bits at or above the pool size, isolates the lowest clear bit
// and returns its position together with the word that has it set.
// ============================================================================
module bffa_scan_unit #(
    parameter int ROW_W  = 7,
    parameter int SIZE_W = 14
) (
    input  logic [bffa_pkg::WORD_W-1:0] word,
    input  logic [ROW_W-1:0]            row,
    input  logic [SIZE_W-1:0]           size,
    output bffa_pkg::scan_res_t         res
);
    import bffa_pkg::*;

    localparam int BASE_W = ROW_W + BIT_W;
    localparam int EXT_W  = ((BASE_W > SIZE_W) ? BASE_W : SIZE_W) + 1;

    logic [EXT_W-1:0]  rem;
    logic              all_ok;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] free_vec;
    logic [WORD_W-1:0] lowest;
    logic [BIT_W-1:0]  idx;

    // Bits of this row that lie below the pool size
    always_comb begin
        rem    = EXT_W'(size) - EXT_W'({row, {BIT_W{1'b0}}});
        all_ok = (rem >= EXT_W'(WORD_W));
        mask   = all_ok ? {WORD_W{1'b1}} : ~({WORD_W{1'b1}} << rem[BIT_W-1:0]);
    end

    // Isolate the lowest clear bit and encode its position
    always_comb begin
        free_vec = ~word & mask;
        lowest   = free_vec & (~free_vec + 1'b1);
        idx      = '0;
        for (int j = 0; j < WORD_W; j++) begin
            if (lowest[j]) begin
                idx = idx | BIT_W'(j);
            end
        end
        res.found    = |free_vec;
        res.bit_idx  = idx;
        res.set_word = word | lowest;
    end

endmodule

// ===== rtl/bitmap_first_free_allocator_top.sv =====
// ============================================================================
// bitmap_first_free_allocator_top: two-pool bitmap first-free allocator
// Inode and block allocation maps with free counts. Allocate finds and sets
// the lowest clear bit; free clears a bit given by its 1-based number.
// ============================================================================
//
//  Channel  Direction  Handshake          Contents
//  s_       in         s_tvalid/s_tready  tdata: number; tuser: kind, pool
//  m_       out        m_tvalid/m_tready  tdata: number_res, free_left;
//                                         tuser: status
//  cfg_     in         cfg_valid/cfg_ready index 0 inode_count, 1 block_count
//
//  An allocate scans rows in order until a free bit turns up: the map RAM
//  delivers one 64-bit row per cycle to the shared lowest-free-bit search
//  unit. A free reads, then writes back the row; a rejected request or an
//  allocate on an empty pool goes to the result without a map access.
//  After reset a clearing pass writes all 2 * 2**ROW_W map rows (256 at the
//  default size) with s_tready low; cfg_ready is always high.
//  One request is in flight at a time; a finished result waits in the output
//  register while the next word is accepted, and the block holds only when
//  that register is still full.
//
module bitmap_first_free_allocator_top #(
    parameter int MAP_BITS = bffa_pkg::MAP_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bffa_pkg::S_TDATA_W-1:0]  s_tdata,   // [13:0] number, [15:14] zero
    input  logic [bffa_pkg::S_TUSER_W-1:0]  s_tuser,   // [0] kind, [1] pool
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bffa_pkg::M_TDATA_W-1:0]  m_tdata,   // [13:0] number_res,
                                                       // [27:14] free_left, [31:28] zero
    output logic [bffa_pkg::M_TUSER_W-1:0]  m_tuser,   // [1:0] status
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bffa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bffa_pkg::CNT_W-1:0]      cfg_data
);
    import bffa_pkg::*;

    localparam int ROWS    = (MAP_BITS + WORD_W - 1) / WORD_W;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_W  = ROW_W + 1;
    localparam int SIZE_W  = $clog2(MAP_BITS + 1);
    localparam int CNT_RST = (MAP_BITS < SIZE_RESET) ? MAP_BITS : SIZE_RESET;

    typedef enum logic [5:0] {
        ST_CLEAR   = 6'b000001,
        ST_IDLE    = 6'b000010,
        ST_SCAN    = 6'b000100,
        ST_FREE_RD = 6'b001000,
        ST_FREE_WR = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]   clr_addr_reg;
    logic [CNT_W-1:0]    inode_size_reg, block_size_reg;
    logic [CNT_W-1:0]    inode_free_reg, block_free_reg;

    logic                pool_reg;
    logic [ROW_W-1:0]    free_row_reg;
    logic [BIT_W-1:0]    free_bit_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [ROW_W-1:0]    last_row_reg, rd_row_reg, chk_row_reg;
    logic                rd_more_reg, chk_vld_reg;
    logic [NUM_W-1:0]    res_num_reg;
    logic [STATUS_W-1:0] res_status_reg;

    logic                out_vld_reg;
    logic [NUM_W-1:0]    out_num_reg;
    logic [CNT_W-1:0]    out_left_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic                s_kind, s_pool;
    logic [NUM_W-1:0]    s_num, num_m1;
    logic [SIZE_W-1:0]   eff_inode, eff_block, eff_cfg, in_size;
    logic                range_bad, in_accept, out_load;

    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr, ram_rd_addr;
    logic [WORD_W-1:0]   ram_wr_data, ram_rd_data;
    scan_res_t           scan;

    // Request fields and effective pool sizes
    always_comb begin
        s_kind    = s_tuser[0];
        s_pool    = s_tuser[1];
        s_num     = s_tdata[NUM_W-1:0];
        num_m1    = s_num - 1'b1;
        eff_inode = (32'(inode_size_reg) > MAP_BITS) ? SIZE_W'(MAP_BITS)
                                                     : SIZE_W'(inode_size_reg);
        eff_block = (32'(block_size_reg) > MAP_BITS) ? SIZE_W'(MAP_BITS)
                                                     : SIZE_W'(block_size_reg);
        eff_cfg   = (32'(cfg_data) > MAP_BITS) ? SIZE_W'(MAP_BITS) : SIZE_W'(cfg_data);
        in_size   = (s_pool == POOL_BLOCK) ? eff_block : eff_inode;
        range_bad = (s_num == '0) || (32'(s_num) > 32'(in_size));
    end

    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_DONE) && (!out_vld_reg || m_tready);

    // Sequencer and map RAM port control
    always_comb begin
        state_next  = state_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = {pool_reg, chk_row_reg};
        ram_wr_data = scan.set_word;
        ram_rd_addr = {pool_reg, rd_row_reg};
        unique case (state_reg)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_addr_reg;
                ram_wr_data = '0;
                if (clr_addr_reg == {ADDR_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_kind == KIND_FREE) begin
                        state_next = range_bad ? ST_DONE : ST_FREE_RD;
                    end else begin
                        state_next = (in_size == '0) ? ST_DONE : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (chk_vld_reg) begin
                    if (scan.found) begin
                        ram_wr_en  = 1'b1;
                        state_next = ST_DONE;
                    end else if (chk_row_reg == last_row_reg) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FREE_RD: begin
                ram_rd_addr = {pool_reg, free_row_reg};
                state_next  = ST_FREE_WR;
            end
            ST_FREE_WR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = {pool_reg, free_row_reg};
                ram_wr_data = ram_rd_data & ~(WORD_W'(1) << free_bit_reg);
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!out_vld_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Control state, counts, size registers and the working request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            inode_size_reg <= CNT_W'(SIZE_RESET);
            block_size_reg <= CNT_W'(SIZE_RESET);
            inode_free_reg <= CNT_W'(CNT_RST);
            block_free_reg <= CNT_W'(CNT_RST);
            rd_more_reg    <= 1'b0;
            chk_vld_reg    <= 1'b0;
            out_vld_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end

            // Register write reloads the pool's free count
            if (cfg_valid) begin
                if (cfg_index == CFG_INODE_COUNT) begin
                    inode_size_reg <= cfg_data;
                    inode_free_reg <= CNT_W'(eff_cfg);
                end else begin
                    block_size_reg <= cfg_data;
                    block_free_reg <= CNT_W'(eff_cfg);
                end
            end

            // Latch a new request
            if (in_accept) begin
                pool_reg     <= s_pool;
                free_row_reg <= ROW_W'(num_m1 >> BIT_W);
                free_bit_reg <= num_m1[BIT_W-1:0];
                size_reg     <= in_size;
                last_row_reg <= ROW_W'((in_size - 1'b1) >> BIT_W);
                rd_row_reg   <= '0;
                rd_more_reg  <= 1'b1;
                chk_vld_reg  <= 1'b0;
                if (s_kind == KIND_FREE) begin
                    res_num_reg    <= s_num;
                    res_status_reg <= range_bad ? STAT_RANGE : STAT_OK;
                end else begin
                    res_num_reg    <= '0;
                    res_status_reg <= STAT_FULL;
                end
            end

            // Row scan: issue the next read while checking the previous row
            if (state_reg == ST_SCAN) begin
                chk_vld_reg <= rd_more_reg;
                chk_row_reg <= rd_row_reg;
                if (rd_more_reg) begin
                    rd_row_reg  <= rd_row_reg + 1'b1;
                    rd_more_reg <= (rd_row_reg != last_row_reg);
                end
                if (chk_vld_reg && scan.found) begin
                    res_num_reg    <= NUM_W'({chk_row_reg, scan.bit_idx}) + 1'b1;
                    res_status_reg <= STAT_OK;
                    if (pool_reg == POOL_BLOCK) begin
                        if (block_free_reg != '0) begin
                            block_free_reg <= block_free_reg - 1'b1;
                        end
                    end else begin
                        if (inode_free_reg != '0) begin
                            inode_free_reg <= inode_free_reg - 1'b1;
                        end
                    end
                end
            end

            // Freed bit: count up, saturating at the largest count
            if (state_reg == ST_FREE_WR) begin
                if (pool_reg == POOL_BLOCK) begin
                    if (block_free_reg != {CNT_W{1'b1}}) begin
                        block_free_reg <= block_free_reg + 1'b1;
                    end
                end else begin
                    if (inode_free_reg != {CNT_W{1'b1}}) begin
                        inode_free_reg <= inode_free_reg + 1'b1;
                    end
                end
            end

            // Output register
            if (out_load) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_num_reg    <= res_num_reg;
            out_status_reg <= res_status_reg;
            out_left_reg   <= (pool_reg == POOL_BLOCK) ? block_free_reg : inode_free_reg;
        end
    end

    // Map storage
    bffa_map_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (WORD_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Lowest free bit search over the returned row
    bffa_scan_unit #(
        .ROW_W  (ROW_W),
        .SIZE_W (SIZE_W)
    ) u_scan (
        .word (ram_rd_data),
        .row  (chk_row_reg),
        .size (size_reg),
        .res  (scan)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {{M_PAD_W{1'b0}}, out_left_reg, out_num_reg};
    assign m_tuser   = out_status_reg;

endmodule

// ===== rtl/bffa_checker.sv =====
// ============================================================================
// bffa_checker: port-level checks for the bitmap first-free allocator
// Watches the request and result streams and is bound to the top level.
// ============================================================================
module bffa_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bffa_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [bffa_pkg::M_TUSER_W-1:0] m_tuser
);
    import bffa_pkg::*;

    // The map clearing pass keeps requests out straight after reset
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("request accepted during the clearing pass");

    // Only one request is worked on at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request accepted while one is in flight");

    // A full pool answers with number zero, a success never does
    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STAT_FULL) |-> (m_tdata[NUM_W-1:0] == '0))
        else $error("pool full result carries a nonzero number");

    a_ok_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == STAT_OK) |-> (m_tdata[NUM_W-1:0] != '0))
        else $error("successful result carries number zero");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result word changed while stalled");

endmodule

bind bitmap_first_free_allocator_top bffa_checker u_bffa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
